// ===== rtl/bgd_pkg.sv =====
// Shared constants and types for the binary to grouped decimal converter.
package bgd_pkg;

	localparam int unsigned VALUE_W    = 63;   // input word width
	localparam int unsigned NUM_DIGITS = 19;   // BCD digits for a 63-bit word
	localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
	localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
	localparam int unsigned GROUP_LEN  = 3;    // digits per comma group

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_SHIFT,
		CELL_MOVE
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/bgd_cell.sv =====
// One BCD digit cell of the conversion chain.
module bgd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bgd_pkg::cell_op_t op,
	input  logic              bit_in,
	input  logic [3:0]        digit_in,
	output logic              bit_out,
	output logic [3:0]        digit
);
	import bgd_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;
	logic [3:0] digit_d;

	// add-3 correction ahead of the doubling shift
	assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_comb begin
		unique case (op)
			CELL_HOLD:  digit_d = digit_q;
			CELL_CLEAR: digit_d = 4'd0;
			CELL_SHIFT: digit_d = {adj[2:0], bit_in};
			CELL_MOVE:  digit_d = digit_in;
			default:    digit_d = digit_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else begin
			digit_q <= digit_d;
		end
	end

endmodule

// ===== rtl/binary_to_grouped_decimal_top.sv =====
// Top level of the binary to grouped decimal text converter.
//
// Converts one unsigned 63-bit word to its decimal text, sent out as ASCII
// words most significant first, with a comma between each group of three
// digits counted from the least significant end; zero gives a single '0'.
// The final character of a value carries last_char. A value is taken while
// idle, then shifted one bit per cycle through a chain of 19 BCD digit cells
// (the double-dabble shift), then leading zero digits are moved out of the
// top cell at one per cycle, keeping at least one digit, then one character
// word is produced per cycle (up to 25 words) whenever the output register
// is free. The next value is taken as soon as the last character has entered
// the output register, while it still waits there.
module binary_to_grouped_decimal_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bgd_pkg::VALUE_W-1:0]     value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      char_code,
	output logic                            last_char
);
	import bgd_pkg::*;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
	localparam logic [DIG_CNT_W-1:0] ALL_DIGITS = DIG_CNT_W'(NUM_DIGITS);
	localparam logic [1:0]           GRP_INIT   = 2'(NUM_DIGITS % GROUP_LEN);
	localparam logic [1:0]           GRP_TOP    = 2'(GROUP_LEN - 1);

	// control state
	state_t                 state_q, state_d;
	logic [VALUE_W-1:0]     val_q, val_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
	logic [DIG_CNT_W-1:0]   digits_left_q, digits_left_d;  // digits not yet sent
	logic [1:0]             grp_q, grp_d;                  // digits_left mod 3
	logic                   comma_pending_q, comma_pending_d;

	// output register
	logic                   out_valid_q, out_valid_d;
	logic [7:0]             char_code_q, char_code_d;
	logic                   last_q, last_d;

	// digit chain
	cell_op_t               cell_op;
	logic                   cell_bit [NUM_DIGITS];
	logic [3:0]             cell_digit [NUM_DIGITS];
	logic [3:0]             top_digit;
	logic                   slot_free;
	logic [1:0]             grp_dec;

	assign top_digit = cell_digit[NUM_DIGITS-1];
	assign slot_free = !out_valid_q || out_ready;
	assign grp_dec   = (grp_q == 2'd0) ? GRP_TOP : (grp_q - 2'd1);

	// cell 0 is least significant; bits enter there, digits move up
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			bgd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (cell_op),
				.bit_in   (val_q[VALUE_W-1]),
				.digit_in (4'd0),
				.bit_out  (cell_bit[i]),
				.digit    (cell_digit[i])
			);
		end else begin : g_rest
			bgd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (cell_op),
				.bit_in   (cell_bit[i-1]),
				.digit_in (cell_digit[i-1]),
				.bit_out  (cell_bit[i]),
				.digit    (cell_digit[i])
			);
		end
	end

	always_comb begin
		state_d         = state_q;
		val_d           = val_q;
		bit_cnt_d       = bit_cnt_q;
		digits_left_d   = digits_left_q;
		grp_d           = grp_q;
		comma_pending_d = comma_pending_q;
		out_valid_d     = out_valid_q && !out_ready;
		char_code_d     = char_code_q;
		last_d          = last_q;
		cell_op         = CELL_HOLD;
		in_ready        = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					val_d           = value;
					bit_cnt_d       = '0;
					digits_left_d   = ALL_DIGITS;
					grp_d           = GRP_INIT;
					comma_pending_d = 1'b0;
					cell_op         = CELL_CLEAR;
					state_d         = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_op   = CELL_SHIFT;
				val_d     = {val_q[VALUE_W-2:0], 1'b0};
				bit_cnt_d = bit_cnt_q + 1'b1;
				if (bit_cnt_q == LAST_BIT) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == 4'd0 && digits_left_q != DIG_CNT_W'(1)) begin
					cell_op       = CELL_MOVE;
					digits_left_d = digits_left_q - 1'b1;
					grp_d         = grp_dec;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					if (comma_pending_q) begin
						char_code_d     = CHAR_COMMA;
						last_d          = 1'b0;
						comma_pending_d = 1'b0;
					end else begin
						char_code_d     = CHAR_ZERO + {4'd0, top_digit};
						last_d          = (digits_left_q == DIG_CNT_W'(1));
						cell_op         = CELL_MOVE;
						digits_left_d   = digits_left_q - 1'b1;
						grp_d           = grp_dec;
						// a whole number of groups still follows: separator next
						comma_pending_d = (digits_left_q != DIG_CNT_W'(1)) && (grp_dec == 2'd0);
						if (digits_left_q == DIG_CNT_W'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			bit_cnt_q       <= '0;
			digits_left_q   <= '0;
			grp_q           <= '0;
			comma_pending_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q         <= state_d;
			bit_cnt_q       <= bit_cnt_d;
			digits_left_q   <= digits_left_d;
			grp_q           <= grp_d;
			comma_pending_q <= comma_pending_d;
			out_valid_q     <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q       <= val_d;
		char_code_q <= char_code_d;
		last_q      <= last_d;
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last_char = last_q;

	// checks
	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> digits_left_q != '0)
		else $error("emit with no digits left");

	a_comma_context: assert property (@(posedge clk) disable iff (!arst_n)
		comma_pending_q |-> (state_q == ST_EMIT) && (digits_left_q != '0))
		else $error("separator pending outside emit");

	a_last_not_comma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> char_code_q != CHAR_COMMA)
		else $error("final word is a separator");

	a_top_is_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		top_digit <= 4'd9)
		else $error("top cell holds a non-decimal digit");

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CONV && bit_cnt_q == '0)
		else $error("accepted word did not start conversion");

endmodule
